FILE: hw/rtl/acpu_pkg.sv
// Shared constants and opcodes for the accumulator machine execute block.
// No dependencies.
package acpu_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_ROWS  = STACK_DEPTH / 2;
    localparam int ROW_AW      = $clog2(STACK_ROWS);

    typedef logic [6:0]          opcode_t;
    typedef logic [STACK_AW-1:0] stack_addr_t;
    typedef logic [ROW_AW-1:0]   row_addr_t;

    localparam opcode_t OP_STC    = 7'd1;
    localparam opcode_t OP_CLC    = 7'd2;
    localparam opcode_t OP_HLT    = 7'd3;
    localparam opcode_t OP_INA    = 7'd4;
    localparam opcode_t OP_INI    = 7'd5;
    localparam opcode_t OP_OUTAB  = 7'd6;
    localparam opcode_t OP_OUTAI  = 7'd7;
    localparam opcode_t OP_OUTII  = 7'd8;
    localparam opcode_t OP_MOVAMX = 7'd9;
    localparam opcode_t OP_MOVAMH = 7'd10;
    localparam opcode_t OP_MOVAML = 7'd11;
    localparam opcode_t OP_MOVASP = 7'd12;
    localparam opcode_t OP_MOVAF  = 7'd13;
    localparam opcode_t OP_MOVAB  = 7'd14;
    localparam opcode_t OP_MOVMXA = 7'd15;
    localparam opcode_t OP_MOVMHA = 7'd16;
    localparam opcode_t OP_MOVMLA = 7'd17;
    localparam opcode_t OP_MOVSPA = 7'd18;
    localparam opcode_t OP_MOVBA  = 7'd19;
    localparam opcode_t OP_MOVI   = 7'd20;
    localparam opcode_t OP_XCHG   = 7'd21;
    localparam opcode_t OP_AND    = 7'd22;
    localparam opcode_t OP_NAND   = 7'd23;
    localparam opcode_t OP_OR     = 7'd24;
    localparam opcode_t OP_NOR    = 7'd25;
    localparam opcode_t OP_XOR    = 7'd26;
    localparam opcode_t OP_XNOR   = 7'd27;
    localparam opcode_t OP_NOT    = 7'd28;
    localparam opcode_t OP_SHL    = 7'd29;
    localparam opcode_t OP_SHR    = 7'd30;
    localparam opcode_t OP_ROL    = 7'd31;
    localparam opcode_t OP_ROR    = 7'd32;
    localparam opcode_t OP_CMP    = 7'd33;
    localparam opcode_t OP_JMPMX  = 7'd34;
    localparam opcode_t OP_JMPI   = 7'd35;
    localparam opcode_t OP_JEMX   = 7'd36;
    localparam opcode_t OP_JEI    = 7'd37;
    localparam opcode_t OP_JNEMX  = 7'd38;
    localparam opcode_t OP_JNEI   = 7'd39;
    localparam opcode_t OP_JGMX   = 7'd40;
    localparam opcode_t OP_JGI    = 7'd41;
    localparam opcode_t OP_JLMX   = 7'd42;
    localparam opcode_t OP_JLI    = 7'd43;
    localparam opcode_t OP_JCMX   = 7'd44;
    localparam opcode_t OP_JCI    = 7'd45;
    localparam opcode_t OP_JNCMX  = 7'd46;
    localparam opcode_t OP_JNCI   = 7'd47;
    localparam opcode_t OP_CALLMX = 7'd48;
    localparam opcode_t OP_CALLI  = 7'd49;
    localparam opcode_t OP_RET    = 7'd50;
    localparam opcode_t OP_PUSHA  = 7'd51;
    localparam opcode_t OP_PUSHB  = 7'd52;
    localparam opcode_t OP_PUSHMX = 7'd53;
    localparam opcode_t OP_PUSHMH = 7'd54;
    localparam opcode_t OP_PUSHML = 7'd55;
    localparam opcode_t OP_PUSHF  = 7'd56;
    localparam opcode_t OP_PUSHI  = 7'd57;
    localparam opcode_t OP_POPA   = 7'd58;
    localparam opcode_t OP_POPB   = 7'd59;
    localparam opcode_t OP_POPMX  = 7'd60;
    localparam opcode_t OP_POPMH  = 7'd61;
    localparam opcode_t OP_POPML  = 7'd62;
    localparam opcode_t OP_ADDA   = 7'd63;
    localparam opcode_t OP_ADDI   = 7'd64;
    localparam opcode_t OP_SUBA   = 7'd65;
    localparam opcode_t OP_SUBI   = 7'd66;
    localparam opcode_t OP_INC    = 7'd67;
    localparam opcode_t OP_DEC    = 7'd68;

    localparam int FLAG_C = 0;
    localparam int FLAG_G = 1;
    localparam int FLAG_L = 2;
    localparam int FLAG_Z = 3;

endpackage

FILE: hw/rtl/acpu_if.sv
// Channel interfaces: instruction in, result out, configuration write.
// Depends on acpu_pkg.
interface acpu_in_if import acpu_pkg::*;;
    logic        valid;
    logic        ready;
    opcode_t     func;
    logic [7:0]  imm_first;
    logic [7:0]  imm_second;
    logic [7:0]  mem_read_data;
    logic [7:0]  uart_rx_byte;

    modport source (output valid, func, imm_first, imm_second, mem_read_data, uart_rx_byte,
                    input ready);
    modport sink   (input valid, func, imm_first, imm_second, mem_read_data, uart_rx_byte,
                    output ready);
endinterface

interface acpu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic [7:0]  acc_value;
    logic [3:0]  flag_bits;
    logic        mem_write_valid;
    logic [15:0] mem_write_addr;
    logic [7:0]  mem_write_data;
    logic        port_write_valid;
    logic [7:0]  port_number;
    logic [7:0]  port_data;
    logic        halted;

    modport source (output valid, next_pc, acc_value, flag_bits, mem_write_valid,
                    mem_write_addr, mem_write_data, port_write_valid, port_number,
                    port_data, halted, input ready);
    modport sink   (input valid, next_pc, acc_value, flag_bits, mem_write_valid,
                    mem_write_addr, mem_write_data, port_write_valid, port_number,
                    port_data, halted, output ready);
endinterface

interface acpu_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_port;

    modport source (output valid, rx_port, input ready);
    modport sink   (input valid, rx_port, output ready);
endinterface

FILE: hw/rtl/accumulator_cpu_execute.sv
// Execute stage of the 8-bit accumulator machine, stack held in two banked RAMs.
// Depends on acpu_pkg and the channel interfaces in acpu_if.sv.
//
// Usage:
//   in_ch  : one beat per instruction (opcode, two immediates, byte at MX, serial byte).
//   out_ch : one beat per instruction with next PC, A, flags, stores and halt state.
//   cfg_ch : writes rx_port; always ready, take it only while the block is idle.
// Order: the stack RAM read is registered together with the instruction beat;
//   execution then loads the output register once the result slot is free.
// Throughput: one instruction per cycle while out_ch is taken. The stack is split into even and odd
//   banks so a two-byte push or pop uses one port of each bank per cycle;
//   a read issued while the previous instruction writes the same entry is
//   forwarded from that write.
// Reset: machine registers, flags, halt and valid bits clear; per-entry valid bits make
//   every stack byte read as zero until written, so no clearing pass is needed.
// Stall: when out_ch is not taken the result holds, the instruction behind it
//   waits in the execute register and in_ch drops ready until the slot frees.
// Once halted, every further instruction returns the unchanged state.
module accumulator_cpu_execute
    import acpu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    acpu_in_if.sink   in_ch,
    acpu_out_if.source out_ch,
    acpu_cfg_if.sink  cfg_ch
);

    logic [7:0]  rx_port_reg;
    logic [7:0]  acc_reg, b_reg, sp_reg;
    logic [15:0] mx_reg, pc_reg;
    logic [3:0]  flags_reg;
    logic        halt_reg;

    logic        e_valid_reg;
    opcode_t     e_func_reg;
    logic [7:0]  e_imm1_reg, e_imm2_reg, e_mem_reg, e_rx_reg;

    logic [7:0]  stk_even_mem [0:STACK_ROWS-1];
    logic [7:0]  stk_odd_mem  [0:STACK_ROWS-1];
    logic [STACK_ROWS-1:0] even_vld_reg, odd_vld_reg;
    logic [7:0]  rd_even_reg, rd_odd_reg, fwd_even_reg, fwd_odd_reg;
    logic        rv_even_reg, rv_odd_reg, hit_even_reg, hit_odd_reg;

    logic        out_valid_reg;
    logic [15:0] o_pc_reg, o_maddr_reg;
    logic [7:0]  o_acc_reg, o_mdata_reg, o_pnum_reg, o_pdat_reg;
    logic [3:0]  o_flags_reg;
    logic        o_mw_reg, o_pw_reg, o_halt_reg;

    logic        exec_fire, in_fire;
    logic [7:0]  acc_next, b_next, sp_next;
    logic [15:0] mx_next, pc_next, imm16;
    logic [3:0]  flags_next;
    logic        halt_next, mw, pw;
    logic [7:0]  pnum, pdat;
    logic        push0_en, push1_en;
    logic [7:0]  push0_data, push1_data;
    logic [7:0]  even_byte, odd_byte, pop1, pop2;
    logic [8:0]  sum9, diff9;
    logic [7:0]  sp_m1;

    logic        we_even, we_odd;
    row_addr_t   wa_even, wa_odd, ra_even, ra_odd;
    logic [7:0]  wd_even, wd_odd;
    stack_addr_t sp_base, rd_a1, rd_a2, sp_p1;

    assign exec_fire    = e_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !e_valid_reg || exec_fire;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign imm16 = {e_imm1_reg, e_imm2_reg};
    assign sp_m1 = sp_reg - 8'd1;

    assign even_byte = hit_even_reg ? fwd_even_reg : (rv_even_reg ? rd_even_reg : 8'd0);
    assign odd_byte  = hit_odd_reg  ? fwd_odd_reg  : (rv_odd_reg  ? rd_odd_reg  : 8'd0);
    assign pop1      = sp_m1[0] ? odd_byte  : even_byte;
    assign pop2      = sp_m1[0] ? even_byte : odd_byte;

    always_comb
    begin
        acc_next   = acc_reg;
        b_next     = b_reg;
        sp_next    = sp_reg;
        mx_next    = mx_reg;
        flags_next = flags_reg;
        halt_next  = halt_reg;
        pc_next    = pc_reg + 16'd1;
        mw         = 1'b0;
        pw         = 1'b0;
        pnum       = 8'd0;
        pdat       = 8'd0;
        push0_en   = 1'b0;
        push1_en   = 1'b0;
        push0_data = 8'd0;
        push1_data = 8'd0;
        sum9       = 9'd0;
        diff9      = 9'd0;
        if (halt_reg)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            case (e_func_reg)
                OP_STC:    flags_next[FLAG_C] = 1'b1;
                OP_CLC:    flags_next[FLAG_C] = 1'b0;
                OP_HLT:    halt_next = 1'b1;
                OP_INA:    acc_next = (b_reg == rx_port_reg) ? e_rx_reg : 8'd0;
                OP_INI:
                begin
                    acc_next = (e_imm1_reg == rx_port_reg) ? e_rx_reg : 8'd0;
                    pc_next  = pc_reg + 16'd2;
                end
                OP_OUTAB:
                begin
                    pw = 1'b1; pnum = b_reg; pdat = acc_reg;
                end
                OP_OUTAI:
                begin
                    pw = 1'b1; pnum = e_imm1_reg; pdat = acc_reg;
                    pc_next = pc_reg + 16'd2;
                end
                OP_OUTII:
                begin
                    pw = 1'b1; pnum = e_imm1_reg; pdat = e_imm2_reg;
                    pc_next = pc_reg + 16'd3;
                end
                OP_MOVAMX: acc_next = e_mem_reg;
                OP_MOVAMH: acc_next = mx_reg[15:8];
                OP_MOVAML: acc_next = mx_reg[7:0];
                OP_MOVASP: acc_next = sp_reg;
                OP_MOVAF:  acc_next = {4'd0, flags_reg};
                OP_MOVAB:  acc_next = b_reg;
                OP_MOVMXA: mw = 1'b1;
                OP_MOVMHA: mx_next[15:8] = acc_reg;
                OP_MOVMLA: mx_next[7:0] = acc_reg;
                OP_MOVSPA: sp_next = acc_reg;
                OP_MOVBA:  b_next = acc_reg;
                OP_MOVI:
                begin
                    acc_next = e_imm1_reg;
                    pc_next  = pc_reg + 16'd2;
                end
                OP_XCHG:
                begin
                    acc_next = b_reg; b_next = acc_reg;
                end
                OP_AND:    acc_next = acc_reg & b_reg;
                OP_NAND:   acc_next = ~(acc_reg & b_reg);
                OP_OR:     acc_next = acc_reg | b_reg;
                OP_NOR:    acc_next = ~(acc_reg | b_reg);
                OP_XOR:    acc_next = acc_reg ^ b_reg;
                OP_XNOR:   acc_next = ~(acc_reg ^ b_reg);
                OP_NOT:    acc_next = ~acc_reg;
                OP_SHL:
                begin
                    flags_next[FLAG_C] = acc_reg[7];
                    acc_next = {acc_reg[6:0], 1'b0};
                end
                OP_SHR:
                begin
                    flags_next[FLAG_C] = acc_reg[0];
                    acc_next = {1'b0, acc_reg[7:1]};
                end
                OP_ROL:    acc_next = {acc_reg[6:0], acc_reg[7]};
                OP_ROR:    acc_next = {acc_reg[0], acc_reg[7:1]};
                OP_CMP:
                begin
                    flags_next[FLAG_Z] = acc_reg == b_reg;
                    flags_next[FLAG_L] = acc_reg < b_reg;
                    flags_next[FLAG_G] = acc_reg > b_reg;
                end
                OP_JMPMX:  pc_next = mx_reg;
                OP_JMPI:   pc_next = imm16;
                OP_JEMX:   pc_next = flags_reg[FLAG_Z]  ? mx_reg : pc_reg + 16'd1;
                OP_JEI:    pc_next = flags_reg[FLAG_Z]  ? imm16  : pc_reg + 16'd3;
                OP_JNEMX:  pc_next = !flags_reg[FLAG_Z] ? mx_reg : pc_reg + 16'd1;
                OP_JNEI:   pc_next = !flags_reg[FLAG_Z] ? imm16  : pc_reg + 16'd3;
                OP_JGMX:   pc_next = flags_reg[FLAG_G]  ? mx_reg : pc_reg + 16'd1;
                OP_JGI:    pc_next = flags_reg[FLAG_G]  ? imm16  : pc_reg + 16'd3;
                OP_JLMX:   pc_next = flags_reg[FLAG_L]  ? mx_reg : pc_reg + 16'd1;
                OP_JLI:    pc_next = flags_reg[FLAG_L]  ? imm16  : pc_reg + 16'd3;
                OP_JCMX:   pc_next = flags_reg[FLAG_C]  ? mx_reg : pc_reg + 16'd1;
                OP_JCI:    pc_next = flags_reg[FLAG_C]  ? imm16  : pc_reg + 16'd3;
                OP_JNCMX:  pc_next = !flags_reg[FLAG_C] ? mx_reg : pc_reg + 16'd1;
                OP_JNCI:   pc_next = !flags_reg[FLAG_C] ? imm16  : pc_reg + 16'd3;
                OP_CALLMX:
                begin
                    push0_en = 1'b1; push1_en = 1'b1;
                    {push0_data, push1_data} = pc_reg + 16'd1;
                    sp_next = sp_reg + 8'd2;
                    pc_next = mx_reg;
                end
                OP_CALLI:
                begin
                    push0_en = 1'b1; push1_en = 1'b1;
                    {push0_data, push1_data} = pc_reg + 16'd3;
                    sp_next = sp_reg + 8'd2;
                    pc_next = imm16;
                end
                OP_RET:
                begin
                    pc_next = {pop2, pop1};
                    sp_next = sp_reg - 8'd2;
                end
                OP_PUSHA:
                begin
                    push0_en = 1'b1; push0_data = acc_reg; sp_next = sp_reg + 8'd1;
                end
                OP_PUSHB:
                begin
                    push0_en = 1'b1; push0_data = b_reg; sp_next = sp_reg + 8'd1;
                end
                OP_PUSHMX:
                begin
                    push0_en = 1'b1; push1_en = 1'b1;
                    push0_data = mx_reg[15:8]; push1_data = mx_reg[7:0];
                    sp_next = sp_reg + 8'd2;
                end
                OP_PUSHMH:
                begin
                    push0_en = 1'b1; push0_data = mx_reg[15:8]; sp_next = sp_reg + 8'd1;
                end
                OP_PUSHML:
                begin
                    push0_en = 1'b1; push0_data = mx_reg[7:0]; sp_next = sp_reg + 8'd1;
                end
                OP_PUSHF:
                begin
                    push0_en = 1'b1; push0_data = {4'd0, flags_reg};
                    sp_next = sp_reg + 8'd1;
                end
                OP_PUSHI:
                begin
                    push0_en = 1'b1; push0_data = e_imm1_reg; sp_next = sp_reg + 8'd1;
                    pc_next = pc_reg + 16'd2;
                end
                OP_POPA:
                begin
                    acc_next = pop1; sp_next = sp_m1;
                end
                OP_POPB:
                begin
                    b_next = pop1; sp_next = sp_m1;
                end
                OP_POPMX:
                begin
                    mx_next = {pop2, pop1}; sp_next = sp_reg - 8'd2;
                end
                OP_POPMH:
                begin
                    mx_next[15:8] = pop1; sp_next = sp_m1;
                end
                OP_POPML:
                begin
                    mx_next[7:0] = pop1; sp_next = sp_m1;
                end
                OP_ADDA:
                begin
                    sum9 = {1'b0, acc_reg} + {1'b0, b_reg};
                    flags_next[FLAG_C] = sum9[8]; acc_next = sum9[7:0];
                end
                OP_ADDI:
                begin
                    sum9 = {1'b0, acc_reg} + {1'b0, e_imm1_reg};
                    flags_next[FLAG_C] = sum9[8]; acc_next = sum9[7:0];
                    pc_next = pc_reg + 16'd2;
                end
                OP_SUBA:
                begin
                    diff9 = {1'b0, acc_reg} - {1'b0, b_reg};
                    flags_next[FLAG_C] = diff9[8]; acc_next = diff9[7:0];
                end
                OP_SUBI:
                begin
                    diff9 = {1'b0, acc_reg} - {1'b0, e_imm1_reg};
                    flags_next[FLAG_C] = diff9[8]; acc_next = diff9[7:0];
                    pc_next = pc_reg + 16'd2;
                end
                OP_INC:
                begin
                    flags_next[FLAG_C] = acc_reg == 8'hFF; acc_next = acc_reg + 8'd1;
                end
                OP_DEC:
                begin
                    flags_next[FLAG_C] = acc_reg == 8'h00; acc_next = acc_reg - 8'd1;
                end
                default: ;
            endcase
        end
    end

    // route the two push slots and the two pop reads onto the even and odd banks
    assign sp_p1   = sp_reg + 8'd1;
    assign we_even = exec_fire && (sp_reg[0] ? push1_en : push0_en);
    assign we_odd  = exec_fire && (sp_reg[0] ? push0_en : push1_en);
    assign wd_even = sp_reg[0] ? push1_data : push0_data;
    assign wd_odd  = sp_reg[0] ? push0_data : push1_data;
    assign wa_even = sp_reg[0] ? sp_p1[STACK_AW-1:1] : sp_reg[STACK_AW-1:1];
    assign wa_odd  = sp_reg[0] ? sp_reg[STACK_AW-1:1] : sp_p1[STACK_AW-1:1];

    assign sp_base = exec_fire ? sp_next : sp_reg;
    assign rd_a1   = sp_base - 8'd1;
    assign rd_a2   = sp_base - 8'd2;
    assign ra_even = rd_a1[0] ? rd_a2[STACK_AW-1:1] : rd_a1[STACK_AW-1:1];
    assign ra_odd  = rd_a1[0] ? rd_a1[STACK_AW-1:1] : rd_a2[STACK_AW-1:1];

    always_ff @(posedge clk)
    begin
        if (we_even)
        begin
            stk_even_mem[wa_even] <= wd_even;
        end
        if (we_odd)
        begin
            stk_odd_mem[wa_odd] <= wd_odd;
        end
        if (in_fire)
        begin
            rd_even_reg  <= stk_even_mem[ra_even];
            rd_odd_reg   <= stk_odd_mem[ra_odd];
            fwd_even_reg <= wd_even;
            fwd_odd_reg  <= wd_odd;
            e_func_reg   <= in_ch.func;
            e_imm1_reg   <= in_ch.imm_first;
            e_imm2_reg   <= in_ch.imm_second;
            e_mem_reg    <= in_ch.mem_read_data;
            e_rx_reg     <= in_ch.uart_rx_byte;
        end
        if (exec_fire)
        begin
            o_pc_reg    <= pc_next;
            o_acc_reg   <= acc_next;
            o_flags_reg <= flags_next;
            o_mw_reg    <= mw;
            o_maddr_reg <= mw ? mx_reg : 16'd0;
            o_mdata_reg <= mw ? acc_reg : 8'd0;
            o_pw_reg    <= pw;
            o_pnum_reg  <= pnum;
            o_pdat_reg  <= pdat;
            o_halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_port_reg   <= 8'd0;
            acc_reg       <= 8'd0;
            b_reg         <= 8'd0;
            sp_reg        <= 8'd0;
            mx_reg        <= 16'd0;
            pc_reg        <= 16'd0;
            flags_reg     <= 4'd0;
            halt_reg      <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            even_vld_reg  <= '0;
            odd_vld_reg   <= '0;
            rv_even_reg   <= 1'b0;
            rv_odd_reg    <= 1'b0;
            hit_even_reg  <= 1'b0;
            hit_odd_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                rx_port_reg <= cfg_ch.rx_port;
            end
            if (in_fire)
            begin
                rv_even_reg  <= even_vld_reg[ra_even];
                rv_odd_reg   <= odd_vld_reg[ra_odd];
                hit_even_reg <= we_even && (wa_even == ra_even);
                hit_odd_reg  <= we_odd && (wa_odd == ra_odd);
            end
            if (we_even)
            begin
                even_vld_reg[wa_even] <= 1'b1;
            end
            if (we_odd)
            begin
                odd_vld_reg[wa_odd] <= 1'b1;
            end
            if (exec_fire)
            begin
                acc_reg   <= acc_next;
                b_reg     <= b_next;
                sp_reg    <= sp_next;
                mx_reg    <= mx_next;
                pc_reg    <= pc_next;
                flags_reg <= flags_next;
                halt_reg  <= halt_next;
            end
            if (in_fire)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                e_valid_reg <= 1'b0;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.next_pc          = o_pc_reg;
    assign out_ch.acc_value        = o_acc_reg;
    assign out_ch.flag_bits        = o_flags_reg;
    assign out_ch.mem_write_valid  = o_mw_reg;
    assign out_ch.mem_write_addr   = o_maddr_reg;
    assign out_ch.mem_write_data   = o_mdata_reg;
    assign out_ch.port_write_valid = o_pw_reg;
    assign out_ch.port_number      = o_pnum_reg;
    assign out_ch.port_data        = o_pdat_reg;
    assign out_ch.halted           = o_halt_reg;

`ifndef SYNTHESIS
    a_no_stack_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> !(we_even || we_odd))
        else $error("stack written while halted");
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt bit cleared");
    a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid_reg)
        else $error("executed instruction lost its result slot");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!e_valid_reg || exec_fire))
        else $error("execute register overwritten");
`endif

endmodule
